// File: sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
// Holds the register map, the configuration bundle and the queue entry type.
// No dependencies; every other file imports this package.
package mbps_pkg;

    // Default sizes handed to the top level as parameter defaults
    localparam int MBPS_MAX_PATTERN  = 16;
    localparam int MBPS_ADDRESS_BITS = 32;

    // Fixed register and field widths
    localparam int MBPS_PAT_BITS  = 128;
    localparam int MBPS_CARE_BITS = 16;
    localparam int MBPS_LEN_BITS  = 5;
    localparam int MBPS_ADDR_OUT  = 32;
    localparam int MBPS_CFG_DATA  = 64;
    localparam int MBPS_CFG_IDX   = 3;

    // Register indexes on the configuration port
    localparam logic [MBPS_CFG_IDX-1:0] MBPS_REG_PAT_LO = 3'd0;
    localparam logic [MBPS_CFG_IDX-1:0] MBPS_REG_PAT_HI = 3'd1;
    localparam logic [MBPS_CFG_IDX-1:0] MBPS_REG_CARE   = 3'd2;
    localparam logic [MBPS_CFG_IDX-1:0] MBPS_REG_LEN    = 3'd3;
    localparam logic [MBPS_CFG_IDX-1:0] MBPS_REG_BASE   = 3'd4;

    // Register reset values
    localparam logic [MBPS_CARE_BITS-1:0] MBPS_CARE_RESET = 16'hFFFF;
    localparam logic [MBPS_LEN_BITS-1:0]  MBPS_LEN_RESET  = 5'd16;

    // Result queue between front and back
    localparam int MBPS_QDEPTH = 2;
    localparam int MBPS_QPTR_W = $clog2(MBPS_QDEPTH);
    localparam int MBPS_QCNT_W = $clog2(MBPS_QDEPTH + 1);

    // Configuration bundle seen by the datapath
    typedef struct packed {
        logic [MBPS_PAT_BITS-1:0]  pattern;
        logic [MBPS_CARE_BITS-1:0] care;
        logic [MBPS_LEN_BITS-1:0]  length;
        logic [MBPS_ADDR_OUT-1:0]  base;
    } mbps_cfg_t;

    // Classified outcome of one byte, waiting for address formation
    typedef struct packed {
        logic                     found;
        logic [MBPS_ADDR_OUT-1:0] offset;
    } mbps_res_t;

endpackage

// File: sv/masked_byte_pattern_search.sv
// A result beat passes through a queue entry and then the output register.
// Throughput: one byte per cycle unless the queue is full (combinational compare).
// A two-entry queue and the output register keep input flowing under output stalls.
// Reset (aresetn, synchronous, active low) empties the queue and output register,
// starts a fresh region, and returns the registers to their reset values.
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN  = mbps_pkg::MBPS_MAX_PATTERN,
    parameter int ADDRESS_BITS = mbps_pkg::MBPS_ADDRESS_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [mbps_pkg::MBPS_CFG_IDX-1:0]  cfg_addr,
    input  logic [mbps_pkg::MBPS_CFG_DATA-1:0] cfg_wr_data,
    // byte stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte
    // result stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] match_address
    output logic [0:0]                         m_tuser    // [0] found
);
    import mbps_pkg::*;

    logic [63:0]               pat_lo_reg, pat_hi_reg;
    logic [MBPS_CARE_BITS-1:0] care_reg;
    logic [MBPS_LEN_BITS-1:0]  len_reg;
    logic [MBPS_ADDR_OUT-1:0]  base_reg;
    mbps_cfg_t                 cfg;
    logic                      q_full, q_valid, q_pop, push;
    mbps_res_t                 push_item, q_item;
    logic                      out_found;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= MBPS_CARE_RESET;
            len_reg    <= MBPS_LEN_RESET;
            base_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                MBPS_REG_PAT_LO: begin
                    pat_lo_reg <= cfg_wr_data;
                end
                MBPS_REG_PAT_HI: begin
                    pat_hi_reg <= cfg_wr_data;
                end
                MBPS_REG_CARE: begin
                    care_reg <= cfg_wr_data[MBPS_CARE_BITS-1:0];
                end
                MBPS_REG_LEN: begin
                    len_reg <= cfg_wr_data[MBPS_LEN_BITS-1:0];
                end
                MBPS_REG_BASE: begin
                    base_reg <= cfg_wr_data[MBPS_ADDR_OUT-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.pattern = {pat_hi_reg, pat_lo_reg};
    assign cfg.care    = care_reg;
    assign cfg.length  = len_reg;
    assign cfg.base    = base_reg;

    assign s_tready = !q_full;

    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_item (push_item)
    );

    mbps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    mbps_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base      (cfg.base),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_found (out_found),
        .out_addr  (m_tdata)
    );

    assign m_tuser = out_found;

endmodule

// File: sv/mbps_front.sv
// Front end: accepts bytes, keeps the sliding window and region state,
// and classifies each byte as match, end-without-match or nothing.
// Depends on mbps_pkg.
module mbps_front #(
    parameter int MAX_PATTERN = mbps_pkg::MBPS_MAX_PATTERN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mbps_pkg::mbps_cfg_t cfg,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push,
    output mbps_pkg::mbps_res_t push_item
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W = LEN_W + 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [7:0]               window_reg [MAX_PATTERN];
    logic [7:0]               shifted    [MAX_PATTERN];
    logic [MBPS_ADDR_OUT-1:0] seen_reg, seen_next, seen_inc;
    logic                     done_reg, done_next;
    logic [LEN_W-1:0]         len;
    logic [MAX_PATTERN-1:0]   pos_ok;
    logic                     hit;
    logic                     accept;

    assign accept = in_valid && in_ready;

    // Clamp the configured length into 1..MAX_PATTERN
    always_comb begin
        if (cfg.length == '0) begin
            len = LEN_W'(1);
        end else if (cfg.length > MBPS_LEN_BITS'(MAX_PATTERN)) begin
            len = MAX_LEN;
        end else begin
            len = cfg.length[LEN_W-1:0];
        end
    end

    // Window after taking this byte, newest in the top entry
    always_comb begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            shifted[i] = window_reg[i + 1];
        end
        shifted[MAX_PATTERN-1] = in_byte;
    end

    // Saturating byte count of the region
    assign seen_inc = (&seen_reg) ? seen_reg : seen_reg + MBPS_ADDR_OUT'(1);

    // Compare each pattern position against its aligned window byte
    always_comb begin
        logic [POS_W-1:0] pos;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pos = POS_W'(MAX_PATTERN) - POS_W'(len) + POS_W'(k);
            pos_ok[k] = (POS_W'(k) >= POS_W'(len)) || !cfg.care[k] ||
                        (shifted[pos[IDX_W-1:0]] == cfg.pattern[8*k +: 8]);
        end
    end

    assign hit = (&pos_ok) && (seen_inc >= MBPS_ADDR_OUT'(len));

    // Hand a result to the queue on a match or at the end of the region
    assign push             = accept && !done_reg && (hit || in_last);
    assign push_item.found  = hit;
    assign push_item.offset = seen_inc - MBPS_ADDR_OUT'(len);

    // Region state: clear on the last beat, freeze once matched
    always_comb begin
        seen_next = seen_reg;
        done_next = done_reg;
        if (accept) begin
            if (in_last) begin
                seen_next = '0;
                done_next = 1'b0;
            end else if (!done_reg) begin
                seen_next = seen_inc;
                done_next = hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

    // Advance the window; bytes after a match are dropped
    always_ff @(posedge aclk) begin
        if (accept && !done_reg) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                window_reg[i] <= shifted[i];
            end
        end
    end

`ifndef ASSERT_OFF
    a_notfound_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !push_item.found) |-> in_last)
        else $error("not-found result raised before the end of the region");

    a_match_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_item.found && !in_last) |=> done_reg)
        else $error("region not frozen after a match");
`endif

endmodule

// File: sv/mbps_queue.sv
// Short result queue decoupling the classifying front from the output back.
// Two entries, so the front keeps taking a beat every cycle while one waits.
// Depends on mbps_pkg.
module mbps_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mbps_pkg::mbps_res_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output mbps_pkg::mbps_res_t pop_item
);
    import mbps_pkg::*;

    mbps_res_t              entry_reg [MBPS_QDEPTH];
    logic [MBPS_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [MBPS_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [MBPS_QCNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == MBPS_QCNT_W'(MBPS_QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + MBPS_QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + MBPS_QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + MBPS_QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - MBPS_QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MBPS_QCNT_W'(MBPS_QDEPTH))
        else $error("result queue occupancy out of range");
`endif

endmodule

// File: sv/mbps_back.sv
// Back end: forms the match address from base and offset and holds the
// result in the output register until the sink takes it.
// Depends on mbps_pkg.
module mbps_back #(
    parameter int ADDRESS_BITS = mbps_pkg::MBPS_ADDRESS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         base,
    input  logic                q_valid,
    input  mbps_pkg::mbps_res_t q_item,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_found,
    output logic [31:0]         out_addr
);
    import mbps_pkg::*;

    localparam int ADDR_W = (ADDRESS_BITS < MBPS_ADDR_OUT) ? ADDRESS_BITS : MBPS_ADDR_OUT;
    localparam logic [MBPS_ADDR_OUT-1:0] ADDR_MASK =
        MBPS_ADDR_OUT'((64'd1 << ADDR_W) - 64'd1);

    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg;
    logic [MBPS_ADDR_OUT-1:0] addr_reg, addr_sum;

    // Take the next entry when the output register is empty or draining
    assign pop      = q_valid && (!out_valid_reg || out_ready);
    assign addr_sum = (base + q_item.offset) & ADDR_MASK;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result; a miss carries address zero
    always_ff @(posedge aclk) begin
        if (pop) begin
            found_reg <= q_item.found;
            addr_reg  <= q_item.found ? addr_sum : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = found_reg;
    assign out_addr  = addr_reg;

`ifndef ASSERT_OFF
    a_miss_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !found_reg) |-> (addr_reg == '0))
        else $error("not-found result with non-zero address");
`endif

endmodule
